### hw/rtl/entity_table_nearest_search_unit_macros.svh
// Assertion macros for the entity table nearest search unit.
`ifndef ENTITY_TABLE_NEAREST_SEARCH_UNIT_MACROS_SVH
`define ENTITY_TABLE_NEAREST_SEARCH_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define ETNS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ETNS_ASSERT_NORST(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ETNS_ASSERT(label, clk, rst_n, prop)
`define ETNS_ASSERT_NORST(label, clk, prop)
`endif
`endif

### hw/rtl/etns_pkg.sv
//------------------------------------------------------------------------------
// etns_pkg
// Shared types and constants of the entity table nearest search unit.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package etns_pkg;
	localparam int ENTRIES = 64;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);

	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_ADD    = 3'd1;
	localparam logic [2:0] OP_UPDATE = 3'd2;
	localparam logic [2:0] OP_REMOVE = 3'd3;
	localparam logic [2:0] OP_NEAR   = 3'd4;
	localparam logic [2:0] OP_LOOKUP = 3'd5;

	localparam logic [16:0] RADIUS_RESET = 17'd60;
	localparam logic [15:0] ABSENT_TYPE  = 16'hFFFF;

	localparam logic [1:0] REG_RADIUS = 2'd0;
	localparam logic [1:0] REG_EXCL   = 2'd1;
	localparam logic [1:0] REG_SELF   = 2'd2;

	// One table entry as it travels around the ring.
	typedef struct packed {
		logic [31:0] key;
		logic [15:0] kind;
		logic [15:0] x;
		logic [15:0] y;
	} entry_t;

	// Control that goes from the sequencer to every cell.
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;
endpackage
`default_nettype wire

### hw/rtl/entity_table_nearest_search_unit.sv
// One operation at a time: a new start is accepted only while busy is low. The table
// rotates once per operation, one slot a cycle, through the ring of cells, and the head
// slot is examined each cycle.
// Reset clears the table, sets search_radius to 60 and the other configuration registers to 0.
// The receiver cannot stall: each result is shown for one cycle with done high.
//------------------------------------------------------------------------------
// entity_table_nearest_search_unit
// Keyed entity table held in a ring of cells, with nearest-entry search.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "entity_table_nearest_search_unit_macros.svh"
module entity_table_nearest_search_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  operation,
	input  wire logic [31:0] key,
	input  wire logic [15:0] kind,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	output logic             done,
	output logic             hit,
	output logic [31:0]      found_key,
	output logic signed [15:0] found_x,
	output logic signed [15:0] found_y,
	output logic [15:0]      found_type,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam int N = etns_pkg::ENTRIES;
	localparam int CW = etns_pkg::CNT_W;

	logic [16:0] radius_q;
	logic [15:0] excl_q;
	logic [31:0] self_q;

	logic        busy_q;
	logic [CW-1:0] cnt_q;
	logic [2:0]  op_q;
	logic [31:0] key_q;
	logic [15:0] kind_q;
	logic [15:0] px_q;
	logic [15:0] py_q;
	logic        done_q;
	logic        matched_q;
	logic [16:0] best_q;
	etns_pkg::entry_t best_e_q;
	logic [15:0] type_q;
	logic        res_hit_q;
	logic [31:0] res_key_q;
	logic [15:0] res_x_q;
	logic [15:0] res_y_q;
	logic [15:0] res_type_q;

	etns_pkg::entry_t cell_e [N];
	etns_pkg::entry_t head;
	etns_pkg::entry_t head_new;
	etns_pkg::cell_ctrl_t ctrl;

	wire logic accept = start && !busy_q;
	wire logic cfg_wr = psel && penable && pwrite;
	wire logic last = (cnt_q == CW'(N - 1));

	assign ctrl.shift = busy_q;
	assign ctrl.clear = accept && (operation == etns_pkg::OP_CLEAR);

	// Ring of cells: cell 0 is the head; the modified head re-enters at the tail.
	for (genvar g = 0; g < N; g++) begin : g_cell
		etns_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctrl  (ctrl),
			.prev  ((g == N - 1) ? head_new : cell_e[(g + 1) % N]),
			.entry (cell_e[g])
		);
	end
	assign head = cell_e[0];

	// Distance from the head slot to the query point.
	logic [16:0] dx, dy;
	logic [17:0] mdist;
	always_comb begin
		logic signed [16:0] sx, sy;
		sx = $signed({head.x[15], head.x}) - $signed({px_q[15], px_q});
		sy = $signed({head.y[15], head.y}) - $signed({py_q[15], py_q});
		dx = sx[16] ? 17'(-sx) : 17'(sx);
		dy = sy[16] ? 17'(-sy) : 17'(sy);
		mdist = {1'b0, dx} + {1'b0, dy};
	end

	wire logic key_eq = !matched_q && (head.key == key_q);
	wire logic free_eq = !matched_q && (head.key == 32'd0);
	wire logic cand = (op_q == etns_pkg::OP_NEAR) && (head.key != 32'd0)
		&& (head.kind != excl_q) && (head.key != self_q)
		&& (mdist <= {1'b0, radius_q})
		&& (!matched_q || mdist[16:0] < best_q);

	// Head slot after this operation's edit.
	always_comb begin
		head_new = head;
		case (op_q)
			etns_pkg::OP_ADD: begin
				if (free_eq) begin
					head_new.key = key_q;
					head_new.kind = kind_q;
					head_new.x = px_q;
					head_new.y = py_q;
				end
			end
			etns_pkg::OP_UPDATE: begin
				if (key_eq) begin
					head_new.x = px_q;
					head_new.y = py_q;
				end
			end
			etns_pkg::OP_REMOVE: begin
				if (key_eq) head_new.key = 32'd0;
			end
			default: begin
			end
		endcase
	end

	// Sequencer: one rotation of the ring per operation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
			matched_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				matched_q <= 1'b0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (op_q == etns_pkg::OP_NEAR) begin
					if (cand) matched_q <= 1'b1;
				end else if (op_q == etns_pkg::OP_ADD) begin
					if (free_eq) matched_q <= 1'b1;
				end else if (key_eq) begin
					matched_q <= 1'b1;
				end
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operation word and running best.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= operation;
			key_q <= key;
			kind_q <= kind;
			px_q <= pos_x;
			py_q <= pos_y;
		end
		if (busy_q && cand) begin
			best_q <= mdist[16:0];
			best_e_q <= head;
		end
		if (busy_q && key_eq) type_q <= head.kind;
	end

	// Result word, formed at the end of the rotation.
	logic        fin_hit;
	logic [31:0] fin_key;
	logic [15:0] fin_x, fin_y, fin_type;
	logic        m_now;
	etns_pkg::entry_t be;
	always_comb begin
		m_now = matched_q;
		be = best_e_q;
		fin_hit = 1'b0;
		fin_key = '0;
		fin_x = '0;
		fin_y = '0;
		fin_type = '0;
		case (op_q)
			etns_pkg::OP_ADD: fin_hit = matched_q || free_eq;
			etns_pkg::OP_UPDATE, etns_pkg::OP_REMOVE: fin_hit = matched_q || key_eq;
			etns_pkg::OP_NEAR: begin
				if (cand) begin
					m_now = 1'b1;
					be = head;
				end
				fin_hit = m_now;
				if (m_now) begin
					fin_key = be.key;
					fin_x = be.x;
					fin_y = be.y;
				end
			end
			etns_pkg::OP_LOOKUP: begin
				fin_hit = matched_q || key_eq;
				fin_type = matched_q ? type_q : (key_eq ? head.kind : etns_pkg::ABSENT_TYPE);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (busy_q && last) begin
			res_hit_q <= fin_hit;
			res_key_q <= fin_key;
			res_x_q <= fin_x;
			res_y_q <= fin_y;
			res_type_q <= fin_type;
		end
	end

	// Configuration registers; clear also drops the observer key.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= etns_pkg::RADIUS_RESET;
			excl_q <= '0;
			self_q <= '0;
		end else begin
			if (cfg_wr && paddr[3:2] == etns_pkg::REG_RADIUS) radius_q <= pwdata[16:0];
			if (cfg_wr && paddr[3:2] == etns_pkg::REG_EXCL) excl_q <= pwdata[15:0];
			if (cfg_wr && paddr[3:2] == etns_pkg::REG_SELF) self_q <= pwdata;
			if (ctrl.clear) self_q <= '0;
		end
	end

	always_comb begin
		case (paddr[3:2])
			etns_pkg::REG_RADIUS: prdata = {15'd0, radius_q};
			etns_pkg::REG_EXCL: prdata = {16'd0, excl_q};
			etns_pkg::REG_SELF: prdata = self_q;
			default: prdata = '0;
		endcase
	end

	assign pready = 1'b1;
	assign busy = busy_q;
	assign done = done_q;
	assign hit = res_hit_q;
	assign found_key = res_key_q;
	assign found_x = res_x_q;
	assign found_y = res_y_q;
	assign found_type = res_type_q;

	`ETNS_ASSERT(a_done_after_last, clk, arst_n, (busy_q && last) |=> done_q)
	`ETNS_ASSERT(a_done_not_busy, clk, arst_n, done_q |-> !busy_q)
	`ETNS_ASSERT(a_cnt_range, clk, arst_n, busy_q |-> (cnt_q < CW'(N)))
	`ETNS_ASSERT(a_accept_busy, clk, arst_n, accept |=> busy_q)
endmodule
`default_nettype wire

### hw/rtl/etns_cell.sv
//------------------------------------------------------------------------------
// etns_cell
// One slot of the rotating table; passes its entry to the next cell on shift.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module etns_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire etns_pkg::cell_ctrl_t ctrl,
	input  wire etns_pkg::entry_t    prev,
	output etns_pkg::entry_t         entry
);
	etns_pkg::entry_t entry_q;

	// Clear empties the slot; shift takes the neighbor's entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (ctrl.clear) begin
			entry_q <= '0;
		end else if (ctrl.shift) begin
			entry_q <= prev;
		end
	end

	assign entry = entry_q;
endmodule
`default_nettype wire
